>>> rtl/core/lets_pkg.sv
// types and constants for the literal escape termination scanner
`default_nettype none

package lets_pkg;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_AFTER_U = 3'd1,
      PH_QUOTE   = 3'd2,
      PH_BODY    = 3'd3,
      PH_BAD     = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EM_IDLE      = 3'd0,
      EM_BACKSLASH = 3'd1,
      EM_OCTAL     = 3'd2,
      EM_HEX       = 3'd3,
      EM_UCN       = 3'd4
   } esc_mode_type;

   typedef enum logic [1:0] {
      ST_UNCHECKED = 2'd0,
      ST_CLEAN     = 2'd1,
      ST_VIOLATION = 2'd2
   } status_type;

   localparam logic [1:0] KIND_OCTAL = 2'd0;
   localparam logic [1:0] KIND_HEX   = 2'd1;
   localparam logic [1:0] KIND_UCN   = 2'd2;

   localparam logic [3:0] OCT_MAX_DIGITS = 4'd3;
   localparam logic [3:0] UCN_SHORT_LEN  = 4'd4;
   localparam logic [3:0] UCN_LONG_LEN   = 4'd8;

   localparam int OFFSET_W = 12;

endpackage

`default_nettype wire

>>> rtl/core/literal_escape_termination_scanner.sv
// literal escape termination scanner: byte-serial check of escape termination
// the result is registered: valid in the cycle after the item flagged last is accepted
// throughput: one byte per cycle; a waiting result stalls input only if it is not taken
// the scan state advances once per accepted byte, between the input handshake
// and the result register
// synchronous active-high reset clears the scan state and the result valid flag
`default_nettype none

module literal_escape_termination_scanner #(
   parameter int MAX_BODY_LEN = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [7:0]                    req_ch,
   input  wire logic                          req_last,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [1:0]                    rsp_status,
   output      logic [1:0]                    rsp_escape_kind,
   output      logic [lets_pkg::OFFSET_W-1:0] rsp_escape_offset
);
   import lets_pkg::*;

   localparam int PosW = $clog2(MAX_BODY_LEN);
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_BODY_LEN - 1);

   phase_type           phase_ff, phase_in;
   logic [7:0]          quote_ff, quote_in;
   esc_mode_type        mode_ff, mode_in;
   logic [3:0]          digits_ff, digits_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [PosW-1:0]     start_ff, start_in;
   logic                viol_ff, viol_in;
   logic [1:0]          vkind_ff, vkind_in;
   logic [PosW-1:0]     voff_ff, voff_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [1:0]          kind_ff, kind_in;
   logic [OFFSET_W-1:0] off_ff, off_in;

   logic                accept;
   logic                is_oct, is_hex, body_go, after_esc;
   logic [PosW+OFFSET_W-1:0] voff_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign voff_ext  = {{OFFSET_W{1'b0}}, voff_ff};

   always_comb begin
      is_oct = req_ch inside {["0":"7"]};
      is_hex = req_ch inside {["0":"9"], ["a":"f"], ["A":"F"]};
   end

   always_comb begin
      phase_in  = phase_ff;
      quote_in  = quote_ff;
      mode_in   = mode_ff;
      digits_in = digits_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      viol_in   = viol_ff;
      vkind_in  = vkind_ff;
      voff_in   = voff_ff;
      status_in = ST_UNCHECKED;
      body_go   = 1'b0;
      after_esc = 1'b0;

      case (phase_ff)
         PH_START: begin
            if (req_ch == "u") begin
               phase_in = PH_AFTER_U;
            end else if (req_ch == "L" || req_ch == "U") begin
               phase_in = PH_QUOTE;
            end else if (req_ch == "'" || req_ch == "\"") begin
               quote_in = req_ch;
               phase_in = PH_BODY;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_AFTER_U: begin
            if (req_ch == "8") begin
               phase_in = PH_QUOTE;
            end else if (req_ch == "'" || req_ch == "\"") begin
               quote_in = req_ch;
               phase_in = PH_BODY;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_QUOTE: begin
            if (req_ch == "'" || req_ch == "\"") begin
               quote_in = req_ch;
               phase_in = PH_BODY;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_BODY: begin
            if (req_last) begin
               if (req_ch == quote_ff) begin
                  status_in = viol_ff ? ST_VIOLATION : ST_CLEAN;
               end
            end else begin
               body_go = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (body_go) begin
         if (!viol_ff) begin
            case (mode_ff)
               EM_IDLE: begin
                  if (req_ch == "\\") begin
                     mode_in  = EM_BACKSLASH;
                     start_in = pos_ff;
                  end
               end
               EM_BACKSLASH: begin
                  if (is_oct) begin
                     mode_in   = EM_OCTAL;
                     digits_in = 4'd1;
                  end else if (req_ch == "x") begin
                     mode_in = EM_HEX;
                  end else if (req_ch == "u" || req_ch == "U") begin
                     mode_in   = EM_UCN;
                     digits_in = (req_ch == "u") ? UCN_SHORT_LEN : UCN_LONG_LEN;
                  end else begin
                     mode_in = EM_IDLE;
                  end
               end
               EM_OCTAL: begin
                  if (digits_ff < OCT_MAX_DIGITS && is_oct) begin
                     digits_in = digits_ff + 4'd1;
                  end else begin
                     after_esc = 1'b1;
                  end
               end
               EM_HEX: begin
                  after_esc = !is_hex;
               end
               EM_UCN: begin
                  if (digits_ff != 4'd0) begin
                     digits_in = digits_ff - 4'd1;
                  end else begin
                     after_esc = 1'b1;
                  end
               end
               default: begin
                  mode_in = EM_IDLE;
               end
            endcase

            // a finished escape must be followed by another backslash
            if (after_esc) begin
               if (req_ch == "\\") begin
                  mode_in  = EM_BACKSLASH;
                  start_in = pos_ff;
               end else begin
                  viol_in = 1'b1;
                  case (mode_ff)
                     EM_OCTAL: vkind_in = KIND_OCTAL;
                     EM_HEX:   vkind_in = KIND_HEX;
                     default:  vkind_in = KIND_UCN;
                  endcase
                  voff_in = start_ff;
                  mode_in = EM_IDLE;
               end
            end
         end
         if (pos_ff < PosMax) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      kind_in = (status_in == ST_VIOLATION) ? vkind_ff : KIND_OCTAL;
      off_in  = (status_in == ST_VIOLATION) ? voff_ext[OFFSET_W-1:0] : '0;

      // end of literal: back to the start state
      if (req_last) begin
         phase_in  = PH_START;
         quote_in  = 8'd0;
         mode_in   = EM_IDLE;
         digits_in = 4'd0;
         pos_in    = '0;
         start_in  = '0;
         viol_in   = 1'b0;
         vkind_in  = KIND_OCTAL;
         voff_in   = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         quote_ff     <= 8'd0;
         mode_ff      <= EM_IDLE;
         digits_ff    <= 4'd0;
         pos_ff       <= '0;
         start_ff     <= '0;
         viol_ff      <= 1'b0;
         vkind_ff     <= KIND_OCTAL;
         voff_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            quote_ff  <= quote_in;
            mode_ff   <= mode_in;
            digits_ff <= digits_in;
            pos_ff    <= pos_in;
            start_ff  <= start_in;
            viol_ff   <= viol_in;
            vkind_ff  <= vkind_in;
            voff_ff   <= voff_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         off_ff    <= off_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_escape_kind   = kind_ff;
   assign rsp_escape_offset = off_ff;

   a_no_report_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_VIOLATION) |-> (kind_ff == KIND_OCTAL && off_ff == '0))
      else $error("kind or offset set without a violation");

   a_mid_item_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_last && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result raised for an item that is not last");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (phase_ff == PH_START && !viol_ff && pos_ff == '0))
      else $error("scan state not cleared after last item");

   a_viol_idle: assert property (@(posedge clock) disable iff (reset)
      viol_ff |-> (mode_ff == EM_IDLE && phase_ff == PH_BODY))
      else $error("escape tracking active after a violation");

endmodule

`default_nettype wire

>>> dv/tb_literal_escape_termination_scanner.sv
// testbench for the literal escape termination scanner: directed and random literals
`timescale 1ns / 100ps
`default_nettype none

module tb_literal_escape_termination_scanner;
   import lets_pkg::*;

   localparam int MAX_BODY_LEN = 4096;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } lit_byte_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [1:0]          kind;
      logic [OFFSET_W-1:0] offset;
   } scan_verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_ch = 8'h00;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [1:0]          rsp_escape_kind;
   logic [OFFSET_W-1:0] rsp_escape_offset;

   literal_escape_termination_scanner #(.MAX_BODY_LEN(MAX_BODY_LEN)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_escape_kind   (rsp_escape_kind),
      .rsp_escape_offset (rsp_escape_offset)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // byte stream waiting to be driven, literal under construction, verdicts due
   lit_byte_type     byte_q[$];
   logic [7:0]       lit_buf[$];
   scan_verdict_type verdicts_due[$];

   int  bytes_queued = 0;
   int  bytes_taken = 0;
   int  fault_count = 0;
   int  n_clean = 0;
   int  n_flagged = 0;
   int  n_unchecked = 0;
   int  kind_tally[3] = '{0, 0, 0};
   bit  req_fire = 1'b0;
   bit  quiet_tail = 1'b0;
   bit  rsp_blocked = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;

   string hex_digits = "0123456789abcdefABCDEF";
   string simple_escapes = "ntr\\'\"a?0";

   // scan state of the literal in flight
   phase_type    lit_phase;
   esc_mode_type esc_state;
   logic [7:0]   open_quote_ch;
   logic [3:0]   esc_count;
   int           body_pos;
   int           esc_begin;
   bit           viol_seen;
   logic [1:0]   viol_kind;
   int           viol_pos;

   function automatic void clear_scan();
      lit_phase     = PH_START;
      esc_state     = EM_IDLE;
      open_quote_ch = 8'h00;
      esc_count     = 4'd0;
      body_pos      = 0;
      esc_begin     = 0;
      viol_seen     = 1'b0;
      viol_kind     = KIND_OCTAL;
      viol_pos      = 0;
   endfunction

   function automatic bit is_octal_digit(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic void take_open_quote(input logic [7:0] c);
      if (c == "'" || c == "\"") begin
         open_quote_ch = c;
         lit_phase = PH_BODY;
      end else begin
         lit_phase = PH_BAD;
      end
   endfunction

   // byte right after a complete escape: another backslash or a violation
   function automatic void end_escape(input logic [7:0] c);
      if (c == "\\") begin
         esc_state = EM_BACKSLASH;
         esc_begin = body_pos;
      end else begin
         viol_seen = 1'b1;
         viol_kind = (esc_state == EM_OCTAL) ? KIND_OCTAL :
                     (esc_state == EM_HEX) ? KIND_HEX : KIND_UCN;
         viol_pos  = esc_begin;
         esc_state = EM_IDLE;
      end
   endfunction

   task automatic predict_byte(input logic [7:0] c, input logic lst);
      scan_verdict_type due;
      status_type       st;
      st = ST_UNCHECKED;
      case (lit_phase)
         PH_START: begin
            if (c == "u") lit_phase = PH_AFTER_U;
            else if (c == "L" || c == "U") lit_phase = PH_QUOTE;
            else take_open_quote(c);
         end
         PH_AFTER_U: begin
            if (c == "8") lit_phase = PH_QUOTE;
            else take_open_quote(c);
         end
         PH_QUOTE: take_open_quote(c);
         PH_BODY: begin
            if (lst) begin
               if (c == open_quote_ch) st = viol_seen ? ST_VIOLATION : ST_CLEAN;
            end else begin
               if (!viol_seen) begin
                  case (esc_state)
                     EM_IDLE: begin
                        if (c == "\\") begin
                           esc_state = EM_BACKSLASH;
                           esc_begin = body_pos;
                        end
                     end
                     EM_BACKSLASH: begin
                        if (is_octal_digit(c)) begin
                           esc_state = EM_OCTAL;
                           esc_count = 4'd1;
                        end else if (c == "x") begin
                           esc_state = EM_HEX;
                        end else if (c == "u" || c == "U") begin
                           esc_state = EM_UCN;
                           esc_count = (c == "u") ? UCN_SHORT_LEN : UCN_LONG_LEN;
                        end else begin
                           esc_state = EM_IDLE;
                        end
                     end
                     EM_OCTAL: begin
                        if (esc_count < OCT_MAX_DIGITS && is_octal_digit(c))
                           esc_count = esc_count + 4'd1;
                        else
                           end_escape(c);
                     end
                     EM_HEX: begin
                        if (!((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                              (c >= "A" && c <= "F")))
                           end_escape(c);
                     end
                     EM_UCN: begin
                        if (esc_count != 4'd0) esc_count = esc_count - 4'd1;
                        else end_escape(c);
                     end
                     default: esc_state = EM_IDLE;
                  endcase
               end
               // position sticks at the top of the body range
               if (body_pos < MAX_BODY_LEN - 1) body_pos++;
            end
         end
         default: ;
      endcase
      if (lst) begin
         due.status = st;
         // kind and offset read as zero unless a violation is reported
         due.kind   = (st == ST_VIOLATION) ? viol_kind : KIND_OCTAL;
         due.offset = (st == ST_VIOLATION) ? viol_pos[OFFSET_W-1:0] : '0;
         verdicts_due.push_back(due);
         clear_scan();
      end
   endtask

   task automatic put(input logic [7:0] c);
      lit_buf.push_back(c);
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endtask

   task automatic commit_literal();
      lit_byte_type it;
      for (int i = 0; i < lit_buf.size(); i++) begin
         it.ch   = lit_buf[i];
         it.last = (i == lit_buf.size() - 1);
         byte_q.push_back(it);
         bytes_queued++;
      end
      lit_buf.delete();
   endtask

   task automatic make_random_literal();
      int         shape;
      int         n;
      logic [7:0] q;
      shape = $urandom_range(0, 19);
      q = $urandom_range(0, 1) ? "\"" : "'";
      if (shape == 0) begin
         // plain noise
         n = $urandom_range(1, 6);
         repeat (n) put(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 5))
            2: put_str("u8");
            3: put("L");
            4: put("u");
            5: put("U");
            default: ;
         endcase
         if (shape == 1) put("R");
         if (shape == 2) begin
            // literal cut short in the prefix or at the opening quote
            if (lit_buf.size() == 0 || $urandom_range(0, 1)) put(q);
         end else begin
            put(q);
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 7))
                  0: repeat ($urandom_range(1, 3)) put(8'($urandom_range(32, 126)));
                  1: begin
                     put("\\");
                     repeat ($urandom_range(1, 4)) put(8'("0" + $urandom_range(0, 7)));
                  end
                  2: begin
                     put_str("\\x");
                     repeat ($urandom_range(0, 4)) put(hex_digits[$urandom_range(0, 21)]);
                  end
                  3: begin
                     put("\\");
                     if ($urandom_range(0, 1)) begin
                        put("u");
                        n = 4;
                     end else begin
                        put("U");
                        n = 8;
                     end
                     repeat (n - $urandom_range(0, 1)) put(8'($urandom_range(0, 255)));
                  end
                  4: begin
                     put("\\");
                     put(simple_escapes[$urandom_range(0, simple_escapes.len() - 1)]);
                  end
                  5: put("\\");
                  6: put(8'($urandom_range(0, 255)));
                  default: put(hex_digits[$urandom_range(0, 21)]);
               endcase
            end
            // mostly the matching quote, sometimes the other one or junk
            case ($urandom_range(0, 11))
               0: put(q == "'" ? "\"" : "'");
               1: put(8'($urandom_range(0, 255)));
               default: put(q);
            endcase
         end
      end
      commit_literal();
   endtask

   task automatic random_literals(input int n_bytes);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < n_bytes) make_random_literal();
   endtask

   task automatic wait_drained();
      while (byte_q.size() != 0 || bytes_taken != bytes_queued || verdicts_due.size() != 0)
         @(posedge clock);
   endtask

   // driver: inputs move on the falling edge
   always @(negedge clock) begin : driver_proc
      lit_byte_type nxt;
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
               nxt = byte_q.pop_front();
               req_valid <= 1'b1;
               req_ch    <= nxt.ch;
               req_last  <= nxt.last;
               if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_blocked) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predicts on each accepted byte, checks each accepted verdict
   always @(posedge clock) begin : monitor_proc
      scan_verdict_type due;
      if (reset) begin
         clear_scan();
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            predict_byte(req_ch, req_last);
            bytes_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: unexpected verdict status %0d kind %0d offset %0d",
                           $time, rsp_status, rsp_escape_kind, rsp_escape_offset);
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_status !== due.status || rsp_escape_kind !== due.kind ||
                   rsp_escape_offset !== due.offset) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"%0t: mismatch: expected status %0d kind %0d offset %0d, ",
                               "got %0d %0d %0d"},
                              $time, due.status, due.kind, due.offset,
                              rsp_status, rsp_escape_kind, rsp_escape_offset);
               end
               case (due.status)
                  ST_CLEAN: n_clean++;
                  ST_VIOLATION: begin
                     n_flagged++;
                     kind_tally[due.kind]++;
                  end
                  default: n_unchecked++;
               endcase
            end
         end
      end
   end

   // long receiver hold-off so the block backs up onto its input
   initial begin
      wait (bytes_taken >= 60);
      @(negedge clock);
      rsp_blocked = 1'b1;
      repeat (300) @(posedge clock);
      rsp_blocked = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      clear_scan();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ends in the prefix, ends on the opening quote, raw literal
      put_str("u");
      commit_literal();
      put_str("'");
      commit_literal();
      put_str("R\"");
      commit_literal();
      // lone backslash before the closing quote is clean
      put_str("\"\\\"");
      commit_literal();
      // octal and hex escapes run into a stray byte
      put_str("\"\\1");
      put(8'hFF);
      put_str("\"");
      commit_literal();
      put_str("'\\x");
      put(8'h00);
      put_str("'");
      commit_literal();
      // universal name cut off by a mismatched close
      put_str("u8'\\u1\"");
      commit_literal();
      wait_drained();

      random_literals(150);
      wait_drained();

      random_literals(140);
      wait_drained();

      quiet_tail = 1'b1;
      random_literals(130);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("scanned %0d bytes in %0d literals: %0d clean, %0d not checkable",
               bytes_taken, n_clean + n_flagged + n_unchecked, n_clean, n_unchecked);
      $display("unterminated escapes flagged: %0d (octal %0d, hex %0d, universal %0d)",
               n_flagged, kind_tally[0], kind_tally[1], kind_tally[2]);
      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d faults", fault_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
